// ===== src/direct_mapped_writeback_cache_hierarchy_unit_macros.svh =====
// Assertion macros shared by the modules of the cache hierarchy.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_HIERARCHY_UNIT_MACROS_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_HIERARCHY_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMWBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMWBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dmwbc_pkg.sv =====
package dmwbc_pkg;

    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int TAG_W      = ADDR_W - 2;
    localparam int MIN_OFFSET = 2;
    localparam int MAX_OFFSET = 10;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 3;

    localparam int IN_BITS     = 2 + ADDR_W + 2;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 6 + 5 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FILTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_INDEX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_INDEX    = 3'd5;

    localparam logic [1:0] FILTER_UNIFIED = 2'd0;
    localparam logic [1:0] FILTER_INSTR   = 2'd1;
    localparam logic [1:0] FILTER_DATA    = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] write_evicts;
        logic [CNT_W-1:0] read_evicts;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] requests;
    } stat_vals_t;

    typedef struct packed {
        logic       en;
        logic [1:0] level;
        logic       hit;
        logic       rd_evict;
        logic       wr_evict;
    } stat_upd_t;

endpackage

// ===== src/dmwbc_ram.sv =====
module dmwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/dmwbc_stats.sv =====
module dmwbc_stats #(
    parameter int MAX_LEVELS = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dmwbc_pkg::stat_upd_t  upd,
    input  logic [1:0]            q_level,
    output dmwbc_pkg::stat_vals_t q_vals
);
    import dmwbc_pkg::*;

    stat_vals_t cnt_reg [MAX_LEVELS];

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                cnt_reg[l] <= '0;
            end
        end else if (upd.en) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                if (upd.level == 2'(l)) begin
                    cnt_reg[l].requests <= sat_inc(cnt_reg[l].requests);
                    if (upd.hit) begin
                        cnt_reg[l].hits <= sat_inc(cnt_reg[l].hits);
                    end else begin
                        cnt_reg[l].misses <= sat_inc(cnt_reg[l].misses);
                    end
                    if (upd.rd_evict) begin
                        cnt_reg[l].read_evicts <= sat_inc(cnt_reg[l].read_evicts);
                    end
                    if (upd.wr_evict) begin
                        cnt_reg[l].write_evicts <= sat_inc(cnt_reg[l].write_evicts);
                    end
                end
            end
        end
    end

    // A level beyond those built reads as zero.
    always_comb begin
        q_vals = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (q_level == 2'(l)) begin
                q_vals = cnt_reg[l];
            end
        end
    end

endmodule

// ===== src/direct_mapped_writeback_cache_hierarchy_unit.sv =====
// Channel  Direction  Payload
// s_       in         tuser: kind; tdata: is_data, is_write, address, stat_level
// m_       out        tdata: filtered, hit_level, dirty_evictions, five counters
// cfg_     in         register index and value, written while cfg_we is high
//
// A statistics query or a filtered access goes straight to the finish state; any other
// access passes the lookup state, then a probe state per level with one line-store
// read and write-back. After reset the line store is cleared one entry a cycle, all
// MAX_LEVELS << MAX_INDEX_BITS entries (49152 by default); no item is taken meanwhile.
// A finished result waits in the output register while the next item is accepted.
`include "direct_mapped_writeback_cache_hierarchy_unit_macros.svh"

module direct_mapped_writeback_cache_hierarchy_unit #(
    parameter int MAX_INDEX_BITS = 14,
    parameter int MAX_LEVELS     = 3
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // is_data, is_write, address, stat_level, zero padding
    input  logic [dmwbc_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // filtered, hit_level, dirty_evictions, stat_requests, stat_hits,
    // stat_misses, stat_read_evicts, stat_write_evicts, zero padding
    output logic [dmwbc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                  cfg_we,
    input  logic [dmwbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dmwbc_pkg::CFG_W-1:0]           cfg_wdata
);
    import dmwbc_pkg::*;

    localparam int LINES   = 1 << MAX_INDEX_BITS;
    localparam int DEPTH   = MAX_LEVELS * LINES;
    localparam int RAM_AW  = $clog2(DEPTH);
    localparam int RAM_W   = TAG_W + 2;
    localparam int SH_W    = $clog2(MAX_OFFSET + MAX_INDEX_BITS + 6);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_PROBE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(DEPTH - 1);

    logic [1:0]        state_reg, state_next;
    logic              clear_reg;
    logic [RAM_AW-1:0] clr_addr_reg;

    logic [1:0]        filter_reg;
    logic [1:0]        level_count_reg;
    logic [3:0]        offset_bits_reg;
    logic [3:0]        idx_bits_reg [3];

    logic              kind_reg;
    logic              filt_reg;
    logic              is_write_reg;
    logic [1:0]        stat_level_reg;
    logic [1:0]        lv_reg;
    logic [1:0]        hit_level_reg;
    logic [2:0]        evict_reg;
    logic [RAM_AW-1:0] slot_reg [MAX_LEVELS+1];
    logic [TAG_W-1:0]  tag_reg  [MAX_LEVELS+1];

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic              s_acc;
    logic              filt_now;
    logic [ADDR_W-1:0] in_addr;
    logic [SH_W-1:0]   off_eff;
    logic [SH_W-1:0]   ib_eff   [MAX_LEVELS];
    logic [MAX_INDEX_BITS-1:0] idx_calc [MAX_LEVELS];
    logic [RAM_AW-1:0] slot_calc [MAX_LEVELS+1];
    logic [TAG_W-1:0]  tag_calc  [MAX_LEVELS+1];
    logic [1:0]        levels_eff;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;
    logic              line_valid, line_dirty;
    logic [TAG_W-1:0]  line_tag;
    logic              probe_hit, probe_evict, probe_last;
    logic              out_load;

    stat_upd_t  upd;
    stat_vals_t q_vals;
    stat_vals_t stat_sel;

    assign s_tready = (state_reg == ST_IDLE) && !clear_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign in_addr  = s_tdata[2 +: ADDR_W];

    assign filt_now = !s_tuser
        && ((filter_reg == FILTER_INSTR && s_tdata[0])
            || (filter_reg == FILTER_DATA && !s_tdata[0]));

    always_comb begin
        if (int'(level_count_reg) == 0) begin
            levels_eff = 2'd1;
        end else if (int'(level_count_reg) > MAX_LEVELS) begin
            levels_eff = 2'(MAX_LEVELS);
        end else begin
            levels_eff = level_count_reg;
        end
    end

    always_comb begin
        if (int'(offset_bits_reg) < MIN_OFFSET) begin
            off_eff = SH_W'(MIN_OFFSET);
        end else if (int'(offset_bits_reg) > MAX_OFFSET) begin
            off_eff = SH_W'(MAX_OFFSET);
        end else begin
            off_eff = SH_W'(offset_bits_reg);
        end
    end

    // Index and tag of every level are worked out as the item is taken.
    always_comb begin
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (int'(idx_bits_reg[l]) > MAX_INDEX_BITS) begin
                ib_eff[l] = SH_W'(MAX_INDEX_BITS);
            end else begin
                ib_eff[l] = SH_W'(idx_bits_reg[l]);
            end
            idx_calc[l]  = MAX_INDEX_BITS'(in_addr >> off_eff)
                & ~({MAX_INDEX_BITS{1'b1}} << ib_eff[l]);
            slot_calc[l] = RAM_AW'({2'(l), idx_calc[l]});
            tag_calc[l]  = TAG_W'(in_addr >> (off_eff + ib_eff[l]));
        end
        slot_calc[MAX_LEVELS] = '0;
        tag_calc[MAX_LEVELS]  = '0;
    end

    assign line_valid  = ram_rdata[TAG_W+1];
    assign line_dirty  = ram_rdata[TAG_W];
    assign line_tag    = ram_rdata[TAG_W-1:0];
    assign probe_hit   = line_valid && (line_tag == tag_reg[0]);
    assign probe_evict = !probe_hit && line_valid && line_dirty;
    assign probe_last  = probe_hit || ((lv_reg + 2'd1) == levels_eff);

    assign ram_raddr = (state_reg == ST_PROBE) ? slot_reg[1] : slot_reg[0];
    assign ram_we    = clear_reg || (state_reg == ST_PROBE);
    assign ram_waddr = clear_reg ? clr_addr_reg : slot_reg[0];

    always_comb begin
        if (clear_reg) begin
            ram_wdata = '0;
        end else if (probe_hit) begin
            ram_wdata = {1'b1, line_dirty | is_write_reg, line_tag};
        end else begin
            ram_wdata = {1'b1, is_write_reg, tag_reg[0]};
        end
    end

    dmwbc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_lines (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign upd.en       = (state_reg == ST_PROBE);
    assign upd.level    = lv_reg;
    assign upd.hit      = probe_hit;
    assign upd.rd_evict = probe_evict && !is_write_reg;
    assign upd.wr_evict = probe_evict && is_write_reg;

    dmwbc_stats #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .q_level (stat_level_reg),
        .q_vals  (q_vals)
    );

    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign stat_sel = kind_reg ? q_vals : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = (s_tuser || filt_now) ? ST_FINISH : ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (probe_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            clear_reg       <= 1'b1;
            clr_addr_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
            filter_reg      <= FILTER_UNIFIED;
            level_count_reg <= 2'd1;
            offset_bits_reg <= 4'd2;
            idx_bits_reg[0] <= 4'd8;
            idx_bits_reg[1] <= 4'd10;
            idx_bits_reg[2] <= 4'd12;
        end else begin
            state_reg <= state_next;
            if (clear_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST) begin
                    clear_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TYPE_FILTER: filter_reg      <= cfg_wdata[1:0];
                    CFG_LEVEL_COUNT: level_count_reg <= cfg_wdata[1:0];
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata;
                    CFG_L1_INDEX:    idx_bits_reg[0] <= cfg_wdata;
                    CFG_L2_INDEX:    idx_bits_reg[1] <= cfg_wdata;
                    CFG_L3_INDEX:    idx_bits_reg[2] <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            kind_reg       <= s_tuser;
            filt_reg       <= filt_now;
            is_write_reg   <= s_tdata[1];
            stat_level_reg <= s_tdata[2 + ADDR_W +: 2];
            lv_reg         <= 2'd0;
            hit_level_reg  <= 2'd0;
            evict_reg      <= 3'd0;
            for (int l = 0; l <= MAX_LEVELS; l++) begin
                slot_reg[l] <= slot_calc[l];
                tag_reg[l]  <= tag_calc[l];
            end
        end else if (state_reg == ST_PROBE) begin
            lv_reg    <= lv_reg + 2'd1;
            evict_reg <= evict_reg | (3'(probe_evict) << lv_reg);
            if (probe_hit) begin
                hit_level_reg <= lv_reg + 2'd1;
            end
            for (int l = 0; l < MAX_LEVELS; l++) begin
                slot_reg[l] <= slot_reg[l+1];
                tag_reg[l]  <= tag_reg[l+1];
            end
        end
        if (out_load) begin
            m_tdata_reg <= OUT_TDATA_W'({stat_sel, evict_reg, hit_level_reg, filt_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `DMWBC_ASSERT_IMP(a_clear_blocks_input, clear_reg, !s_tready, "item offered during line clearing was taken")
    `DMWBC_ASSERT_IMP(a_probe_in_range, state_reg == ST_PROBE, lv_reg < levels_eff, "probe beyond the levels in use")
    `DMWBC_ASSERT_IMP(a_ram_write_source, ram_we, clear_reg || state_reg == ST_PROBE, "line store written outside a probe")
    `DMWBC_ASSERT_IMP(a_l1_hit_no_evict, m_tvalid_reg && m_tdata_reg[2:1] == 2'd1, m_tdata_reg[5:3] == 3'd0, "first-level hit reports an eviction")
    `DMWBC_ASSERT_NXT(a_lookup_to_probe, state_reg == ST_LOOKUP && aresetn, state_reg == ST_PROBE && lv_reg == 2'd0, "first probe not at level one")

endmodule

// ===== sim/tb_direct_mapped_writeback_cache_hierarchy_unit.sv =====
`timescale 1ns / 1ps

module tb_direct_mapped_writeback_cache_hierarchy_unit;
    import dmwbc_pkg::*;

    localparam int  TB_MAX_INDEX = 14;
    localparam int  TB_LEVELS    = 3;
    localparam int  TB_LINES     = 1 << TB_MAX_INDEX;
    localparam int  PHASES       = 10;
    localparam int  PHASE_ITEMS  = 95;
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;
    localparam logic [1:0] FILTER_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        kind;
        logic        is_data;
        logic        is_write;
        logic [31:0] address;
        logic [1:0]  stat_level;
    } cache_item_t;

    typedef struct packed {
        logic       filtered;
        logic [1:0] hit_level;
        logic [2:0] evicts;
        stat_vals_t stats;
    } hier_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    direct_mapped_writeback_cache_hierarchy_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Shadow configuration and line store of the hierarchy.
    logic [1:0]  filter_reg = FILTER_UNIFIED;
    logic [1:0]  level_reg  = 2'd1;
    logic [3:0]  offset_reg = 4'd2;
    logic [3:0]  index_reg [TB_LEVELS] = '{4'd8, 4'd10, 4'd12};

    bit          line_ok  [TB_LEVELS][TB_LINES];
    bit          line_mod [TB_LEVELS][TB_LINES];
    logic [29:0] line_tag [TB_LEVELS][TB_LINES];
    bit [31:0]   req_cnt [TB_LEVELS];
    bit [31:0]   hit_cnt [TB_LEVELS];
    bit [31:0]   miss_cnt [TB_LEVELS];
    bit [31:0]   rd_evict_cnt [TB_LEVELS];
    bit [31:0]   wr_evict_cnt [TB_LEVELS];

    cache_item_t  pending_q [$];
    hier_result_t expected_q [$];
    cache_item_t  cur_item;
    logic [31:0]  addr_pool [8];
    int           send_gap = 0;
    int           sink_stall = 0;
    int           src_idle_pct = 30;
    int           sink_idle_pct = 30;
    int           fail_count = 0;
    int           result_count = 0;

    function automatic bit [31:0] sat_inc(input bit [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function automatic int eff_offset();
        if (offset_reg < MIN_OFFSET) return MIN_OFFSET;
        if (offset_reg > MAX_OFFSET) return MAX_OFFSET;
        return offset_reg;
    endfunction

    function automatic int eff_index(input int lv);
        return (index_reg[lv] > TB_MAX_INDEX) ? TB_MAX_INDEX : index_reg[lv];
    endfunction

    function automatic hier_result_t predict_result(input cache_item_t it);
        hier_result_t res;
        int           levels;
        int           off;
        int           ib;
        int           lv;
        logic [31:0]  idx;
        logic [31:0]  tag;
        bit           done;
        res = '0;
        if (it.kind == KIND_QUERY) begin
            if (it.stat_level < TB_LEVELS) begin
                res.stats.requests     = req_cnt[it.stat_level];
                res.stats.hits         = hit_cnt[it.stat_level];
                res.stats.misses       = miss_cnt[it.stat_level];
                res.stats.read_evicts  = rd_evict_cnt[it.stat_level];
                res.stats.write_evicts = wr_evict_cnt[it.stat_level];
            end
            return res;
        end
        if ((filter_reg == FILTER_INSTR && it.is_data) ||
            (filter_reg == FILTER_DATA && !it.is_data)) begin
            res.filtered = 1'b1;
            return res;
        end
        levels = (level_reg == 2'd0) ? 1 : int'(level_reg);
        if (levels > TB_LEVELS) levels = TB_LEVELS;
        off = eff_offset();
        done = 1'b0;
        for (lv = 0; lv < levels && !done; lv++) begin
            ib  = eff_index(lv);
            idx = (it.address >> off) & ((32'd1 << ib) - 32'd1);
            tag = it.address >> (off + ib);
            req_cnt[lv] = sat_inc(req_cnt[lv]);
            if (line_ok[lv][idx] && line_tag[lv][idx] == tag[29:0]) begin
                hit_cnt[lv] = sat_inc(hit_cnt[lv]);
                if (it.is_write) line_mod[lv][idx] = 1'b1;
                res.hit_level = 2'(lv + 1);
                done = 1'b1;
            end else begin
                miss_cnt[lv] = sat_inc(miss_cnt[lv]);
                if (line_ok[lv][idx] && line_mod[lv][idx]) begin
                    res.evicts[lv] = 1'b1;
                    if (it.is_write) wr_evict_cnt[lv] = sat_inc(wr_evict_cnt[lv]);
                    else rd_evict_cnt[lv] = sat_inc(rd_evict_cnt[lv]);
                end
                line_tag[lv][idx] = tag[29:0];
                line_ok[lv][idx]  = 1'b1;
                line_mod[lv][idx] = it.is_write;
            end
        end
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic compare_result(input hier_result_t want, input hier_result_t got);
        string tagline;
        tagline = $sformatf("result %0d", result_count);
        if (got.filtered !== want.filtered)
            report_error($sformatf("%s filtered: expected %0h got %0h", tagline,
                                   want.filtered, got.filtered));
        if (got.hit_level !== want.hit_level)
            report_error($sformatf("%s hit_level: expected %0h got %0h", tagline,
                                   want.hit_level, got.hit_level));
        if (got.evicts !== want.evicts)
            report_error($sformatf("%s dirty_evictions: expected %0h got %0h", tagline,
                                   want.evicts, got.evicts));
        if (got.stats.requests !== want.stats.requests)
            report_error($sformatf("%s stat_requests: expected %0h got %0h", tagline,
                                   want.stats.requests, got.stats.requests));
        if (got.stats.hits !== want.stats.hits)
            report_error($sformatf("%s stat_hits: expected %0h got %0h", tagline,
                                   want.stats.hits, got.stats.hits));
        if (got.stats.misses !== want.stats.misses)
            report_error($sformatf("%s stat_misses: expected %0h got %0h", tagline,
                                   want.stats.misses, got.stats.misses));
        if (got.stats.read_evicts !== want.stats.read_evicts)
            report_error($sformatf("%s stat_read_evicts: expected %0h got %0h", tagline,
                                   want.stats.read_evicts, got.stats.read_evicts));
        if (got.stats.write_evicts !== want.stats.write_evicts)
            report_error($sformatf("%s stat_write_evicts: expected %0h got %0h", tagline,
                                   want.stats.write_evicts, got.stats.write_evicts));
    endtask

    // The prediction is made when the block takes the item, so it follows acceptance order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_result(cur_item));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    cur_item = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.kind;
                    s_tdata  <= IN_TDATA_W'({cur_item.stat_level, cur_item.address,
                                             cur_item.is_write, cur_item.is_data});
                    if ($urandom_range(0, 99) < src_idle_pct)
                        send_gap = $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        hier_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.filtered  = m_tdata[0];
                got.hit_level = m_tdata[2:1];
                got.evicts    = m_tdata[5:3];
                got.stats     = m_tdata[6 +: 5 * CNT_W];
                if (expected_q.size() == 0)
                    report_error("result arrived with nothing outstanding");
                else
                    compare_result(expected_q.pop_front(), got);
                result_count++;
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                sink_stall = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic kind, input logic is_data, input logic is_write,
                             input logic [31:0] address, input logic [1:0] stat_level);
        cache_item_t it;
        it.kind       = kind;
        it.is_data    = is_data;
        it.is_write   = is_write;
        it.address    = address;
        it.stat_level = stat_level;
        pending_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_TYPE_FILTER: filter_reg   = val[1:0];
            CFG_LEVEL_COUNT: level_reg    = val[1:0];
            CFG_OFFSET_BITS: offset_reg   = val;
            CFG_L1_INDEX:    index_reg[0] = val;
            CFG_L2_INDEX:    index_reg[1] = val;
            CFG_L3_INDEX:    index_reg[2] = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [3:0] filt, input logic [3:0] levels,
                              input logic [3:0] off, input logic [3:0] ib1,
                              input logic [3:0] ib2, input logic [3:0] ib3);
        wait_idle();
        write_reg(CFG_TYPE_FILTER, filt);
        write_reg(CFG_LEVEL_COUNT, levels);
        write_reg(CFG_OFFSET_BITS, off);
        write_reg(CFG_L1_INDEX, ib1);
        write_reg(CFG_L2_INDEX, ib2);
        write_reg(CFG_L3_INDEX, ib3);
    endtask

    // Most accesses revisit a small pool of lines, so that hits, deeper hits and
    // dirty evictions are frequent; the rest are scattered addresses and queries.
    task automatic add_random_items(input int count);
        int          n;
        int          r;
        int          j;
        int          off;
        int          ib1;
        logic [31:0] addr;
        off = eff_offset();
        ib1 = eff_index(0);
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            j = $urandom_range(0, 7);
            if (r < 40)
                addr = addr_pool[j] ^ ($urandom & ((32'd1 << off) - 32'd1));
            else if (r < 65)
                addr = addr_pool[j] ^ (32'd1 << $urandom_range(off + ib1, 31));
            else if (r < 75)
                addr = addr_pool[j] ^ (32'd1 << $urandom_range(off, 31));
            else if (r < 85)
                addr = $urandom;
            else
                addr = addr_pool[j];
            push_item(($urandom_range(0, 99) < 8) ? KIND_QUERY : KIND_ACCESS,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), addr,
                      2'($urandom_range(0, 3)));
        end
    endtask

    initial begin
        int p;
        int k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: one level of 256 four-byte lines.
        push_item(KIND_QUERY, 1'b0, 1'b0, 32'h0, 2'd0);
        push_item(KIND_QUERY, 1'b1, 1'b1, 32'hFFFF_FFFF, 2'd3);
        push_item(KIND_ACCESS, 1'b0, 1'b0, 32'h0, 2'd0);
        push_item(KIND_ACCESS, 1'b1, 1'b0, 32'h0, 2'd0);

        set_config(FILTER_UNIFIED, 4'd3, 4'd2, 4'd8, 4'd10, 4'd12);
        push_item(KIND_ACCESS, 1'b1, 1'b1, 32'hFFFF_FFFF, 2'd3);
        push_item(KIND_ACCESS, 1'b1, 1'b0, 32'hFFFF_FFFF, 2'd3);
        push_item(KIND_ACCESS, 1'b1, 1'b1, 32'h7FFF_FFFF, 2'd0);
        push_item(KIND_ACCESS, 1'b0, 1'b0, 32'hFFFF_FFFF, 2'd0);
        push_item(KIND_ACCESS, 1'b1, 1'b0, 32'h0000_1000, 2'd0);
        push_item(KIND_ACCESS, 1'b1, 1'b0, 32'h0000_1400, 2'd0);
        push_item(KIND_ACCESS, 1'b1, 1'b0, 32'h0000_1000, 2'd0);
        push_item(KIND_ACCESS, 1'b1, 1'b0, 32'h0000_0000, 2'd0);
        push_item(KIND_ACCESS, 1'b1, 1'b0, 32'h0000_1000, 2'd0);
        for (k = 0; k < 4; k++)
            push_item(KIND_QUERY, 1'b0, 1'b0, 32'h0, 2'(k));

        set_config(FILTER_INSTR, 4'd3, 4'd2, 4'd8, 4'd10, 4'd12);
        push_item(KIND_ACCESS, 1'b1, 1'b1, 32'h0000_1000, 2'd0);
        push_item(KIND_ACCESS, 1'b0, 1'b1, 32'h0000_1000, 2'd0);

        set_config(FILTER_DATA, 4'd3, 4'd2, 4'd8, 4'd10, 4'd12);
        push_item(KIND_ACCESS, 1'b0, 1'b0, 32'h0000_1000, 2'd0);
        push_item(KIND_ACCESS, 1'b1, 1'b0, 32'h0000_1000, 2'd0);

        for (k = 0; k < 8; k++)
            addr_pool[k] = $urandom;

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(FILTER_UNIFIED, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0);
                1: set_config(FILTER_INSTR, 4'd2, 4'd10, 4'd14, 4'd14, 4'd14);
                2: set_config(FILTER_DATA, 4'd3, 4'd15, 4'd15, 4'd15, 4'd15);
                3: set_config(FILTER_SPARE, 4'd0, 4'd0, 4'd1, 4'd2, 4'd3);
                4: set_config(4'hF, 4'd3, 4'd4, 4'd2, 4'd3, 4'd4);
                default: set_config(4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)),
                                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            endcase
            if (p == 4) begin
                write_reg(CFG_SPARE_LO, 4'hF);
                write_reg(CFG_SPARE_HI, 4'($urandom));
            end
            if (p == PHASES - 1) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = 20 * $urandom_range(0, 2);
                sink_idle_pct = 20 * $urandom_range(0, 2);
            end
            // At least half of the pool is kept, so lines installed under the old split are revisited.
            for (k = 0; k < 4; k++)
                addr_pool[$urandom_range(0, 7)] = $urandom;
            add_random_items(PHASE_ITEMS);
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== direct_mapped_writeback_cache_hierarchy_unit.f =====
+incdir+src
src/dmwbc_pkg.sv
src/dmwbc_ram.sv
src/dmwbc_stats.sv
src/direct_mapped_writeback_cache_hierarchy_unit.sv
sim/tb_direct_mapped_writeback_cache_hierarchy_unit.sv
